>>> rtl/lrr_pkg.sv
`timescale 1ns / 1ps

package lrr_pkg;

  // Generator constants: seed' = seed * LCG_MULTIPLIER mod LCG_MODULUS.
  localparam logic [30:0] LCG_MODULUS    = 31'd2147483399;
  localparam logic [15:0] LCG_MULTIPLIER = 16'd40692;
  localparam logic [30:0] SEED_START     = 31'h0f0f0f0f;
  // 2^31 mod LCG_MODULUS, used to fold the high part of the product.
  localparam logic [7:0]  FOLD_FACTOR    = 8'd249;

  // Request codes carried in the input tuser field.
  localparam logic [1:0] MODE_RAW     = 2'd0;
  localparam logic [1:0] MODE_RANGED  = 2'd1;
  localparam logic [1:0] MODE_RESTORE = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 32;

  // What the back end has to do with a queued request.
  typedef enum logic [2:0] {
    KIND_RAW,
    KIND_PARITY,
    KIND_RANGED,
    KIND_RESTORE,
    KIND_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] base;
    logic [31:0] span;
  } job_t;

endpackage

>>> rtl/lrr_front.sv
`timescale 1ns / 1ps

module lrr_front (
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // lower_bound [31:0], upper_bound [63:32]
  input  logic [1:0]   s_axis_tuser,  // mode [1:0]
  input  logic         full,
  output logic         push,
  output lrr_pkg::job_t job
);
  import lrr_pkg::*;

  logic [31:0] lo;
  logic [31:0] hi;
  logic        swap;
  logic [31:0] top_bound;

  assign lo        = s_axis_tdata[31:0];
  assign hi        = s_axis_tdata[63:32];
  assign swap      = $signed(hi) < $signed(lo);
  assign top_bound = swap ? lo : hi;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  always_comb begin
    job.base = swap ? hi : lo;
    // Unsigned difference of the ordered bounds; never zero when they differ.
    job.span = top_bound - job.base;
    case (s_axis_tuser)
      MODE_RAW: begin
        job.kind = KIND_RAW;
      end
      MODE_RANGED: begin
        job.kind = (lo == hi) ? KIND_PARITY : KIND_RANGED;
      end
      MODE_RESTORE: begin
        job.kind = KIND_RESTORE;
      end
      default: begin
        job.kind = KIND_IGNORE;
      end
    endcase
  end

endmodule

>>> rtl/lrr_queue.sv
`timescale 1ns / 1ps

module lrr_queue #(
  parameter int QUEUE_DEPTH = lrr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lrr_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output lrr_pkg::job_t head
);
  import lrr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/lrr_back.sv
`timescale 1ns / 1ps

module lrr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  lrr_pkg::job_t head,
  output logic          pop,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata   // value [31:0]
);
  import lrr_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD,
    ST_RED,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t            state;
  logic [30:0]       seed;
  job_t              job;
  logic [46:0]       prod;
  logic [31:0]       fold;
  logic [30:0]       draw;
  logic [31:0]       dividend;
  logic [32:0]       rem;
  logic [STEP_W-1:0] step;

  logic [46:0] mul_calc;
  logic [31:0] fold_calc;
  logic [31:0] red_calc;
  logic [32:0] rem_sh;
  logic [32:0] span_ext;
  logic [31:0] result_calc;

  assign pop = (state == ST_IDLE) && !empty;

  assign mul_calc = seed * LCG_MULTIPLIER;
  // prod = h * 2^31 + l, and 2^31 is congruent to FOLD_FACTOR, so the fold
  // leaves a value below twice the modulus.
  assign fold_calc = 32'(prod[46:31]) * 32'(FOLD_FACTOR) + 32'(prod[30:0]);
  assign red_calc  = (fold >= 32'(LCG_MODULUS)) ? fold - 32'(LCG_MODULUS) : fold;

  assign rem_sh   = {rem[31:0], dividend[31]};
  assign span_ext = {1'b0, job.span};

  always_comb begin
    case (job.kind)
      KIND_RAW:    result_calc = {1'b0, draw};
      KIND_PARITY: result_calc = job.base + 32'(draw[0]);
      KIND_RANGED: result_calc = rem[31:0] + job.base;
      default:     result_calc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seed          <= SEED_START;
      m_axis_tvalid <= 1'b0;
    end else begin
      // In ST_DONE the output register is handled by that state alone.
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            job <= head;
            if (head.kind inside {KIND_RAW, KIND_PARITY, KIND_RANGED}) begin
              state <= ST_MUL;
            end else begin
              if (head.kind == KIND_RESTORE) begin
                seed <= SEED_START;
              end
              state <= ST_DONE;
            end
          end
        end
        ST_MUL: begin
          prod  <= mul_calc;
          state <= ST_FOLD;
        end
        ST_FOLD: begin
          fold  <= fold_calc;
          state <= ST_RED;
        end
        ST_RED: begin
          seed     <= red_calc[30:0];
          draw     <= red_calc[30:0];
          dividend <= {1'b0, red_calc[30:0]};
          rem      <= '0;
          step     <= '0;
          state    <= (job.kind == KIND_RANGED) ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          // One restoring step: bring in the next dividend bit, subtract if it fits.
          rem      <= (rem_sh >= span_ext) ? rem_sh - span_ext : rem_sh;
          dividend <= {dividend[30:0], 1'b0};
          step     <= step + 1'b1;
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= result_calc;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/lehmer_random_in_range_top.sv
`timescale 1ns / 1ps
// A ranged draw with distinct bounds passes through the multiply, fold, reduce and
// restoring remainder states; a raw draw or equal bounds skips the remainder loop, and
// restore or mode 3 goes straight to the output. The back end works on one request at
// a time and pops the next one from the queue only once it is idle again.
// Reset (rst, synchronous, active high) loads the seed with 0x0f0f0f0f, empties the
// request queue and drops m_axis_tvalid.

module lehmer_random_in_range_top #(
  parameter int QUEUE_DEPTH = lrr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // lower_bound [31:0], upper_bound [63:32]
  input  logic [1:0]  s_axis_tuser,   // mode [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // value [31:0]
);
  import lrr_pkg::*;

  // The front end orders the bounds and forms their difference as each transaction
  // arrives, so the queue holds ready-to-run jobs. The back end owns the seed:
  // a 31x16 multiply, a fold of the high product bits (2^31 mod m is 249) and one
  // conditional subtract give the next seed; a ranged draw with distinct bounds then
  // runs a 32-step restoring remainder against the stored span. Results wait in
  // one output register; the front end keeps taking requests until the queue is full.

  logic full;
  logic push;
  job_t push_job;
  logic pop;
  logic empty;
  job_t head;

  lrr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full          (full),
    .push          (push),
    .job           (push_job)
  );

  lrr_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  lrr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> rtl/lrr_checker.sv
`timescale 1ns / 1ps

module lrr_checker #(
  parameter int QUEUE_DEPTH = lrr_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Queue entries plus the job in the back end plus the output register.
  localparam int MAX_OPEN = QUEUE_DEPTH + 2;
  localparam int CNT_W    = $clog2(MAX_OPEN + 1);

  logic [CNT_W-1:0] open_cnt;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_cnt <= '0;
    end else if (in_acc && !out_acc) begin
      open_cnt <= open_cnt + 1'b1;
    end else if (out_acc && !in_acc) begin
      open_cnt <= open_cnt - 1'b1;
    end
  end

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> open_cnt != '0)
    else $error("result without an outstanding request");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    open_cnt <= CNT_W'(MAX_OPEN))
    else $error("more requests in flight than the block can hold");

endmodule

bind lehmer_random_in_range_top lrr_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lrr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
